FILE: rtl/life_automaton_grid_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the life automaton grid
// Wrap concurrent checks on clk_i with rst_ni as the disable condition.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GRID_MACROS_SVH
`define LIFE_AUTOMATON_GRID_MACROS_SVH

// Same-cycle implication
`define LAG_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication
`define LAG_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// Shared sizes, codes, command struct and the B3/S23 row update function.
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int MaxRows   = 64;
  localparam int MaxCols   = 64;
  localparam int CfgW      = 7;
  localparam int CfgIdxW   = 1;
  localparam int OpW       = 2;
  localparam int FieldRowW = 6;
  localparam int FieldColW = 6;

  localparam int RowW   = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int Depth  = 2 ** RowW;
  localparam int CntW   = $clog2(MaxRows + 3);
  localparam int NcW    = $clog2(MaxCols + 1);
  localparam int WideW0 = (CfgW > CntW) ? CfgW : CntW;
  localparam int WideW  = (WideW0 > NcW) ? WideW0 : NcW;

  localparam logic [CfgW-1:0] RegReset = 7'd64;

  localparam logic [3:0] BirthCount = 4'd3;
  localparam logic [3:0] KeepCount  = 4'd2;

  typedef enum logic [OpW-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  localparam logic [CfgIdxW-1:0] CFG_ROWS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COLS = 1'b1;

  typedef logic [MaxCols-1:0] row_word_t;

  typedef struct packed {
    logic            cap;
    logic            win_clr;
    logic            req_rd;
    logic            adv_rd;
    logic [RowW-1:0] rd_addr;
    logic            cell_wr;
    logic            shift;
    logic            blank;
    logic            adv_wr;
    logic [RowW-1:0] wr_addr;
    logic            res_cap;
    logic            out_load;
  } lag_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] nr;
  } lag_stat_t;

  // New row from three old rows; columns outside the mask keep their bits
  function automatic row_word_t lag_next_row(row_word_t p, row_word_t c, row_word_t n,
                                             row_word_t m);
    logic [MaxCols+1:0] pp;
    logic [MaxCols+1:0] cp;
    logic [MaxCols+1:0] np;
    row_word_t          nw;
    logic [3:0]         cnt;
    pp = {1'b0, p & m, 1'b0};
    cp = {1'b0, c & m, 1'b0};
    np = {1'b0, n & m, 1'b0};
    nw = '0;
    for (int i = 0; i < MaxCols; i++) begin
      cnt = 4'(pp[i]) + 4'(pp[i+1]) + 4'(pp[i+2]) +
            4'(cp[i]) + 4'(cp[i+2]) +
            4'(np[i]) + 4'(np[i+1]) + 4'(np[i+2]);
      nw[i] = (cnt == BirthCount) || (cp[i+1] && (cnt == KeepCount));
    end
    return (nw & m) | (c & ~m);
  endfunction

endpackage

FILE: rtl/lag_if.sv
// ----------------------------------------------------------------------------
// lag_if
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
interface lag_in_if import lag_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       operation;
  logic [FieldRowW-1:0] row;
  logic [FieldColW-1:0] col;
  logic                 write_value;

  modport source (output valid, operation, row, col, write_value, input ready);
  modport sink   (input valid, operation, row, col, write_value, output ready);
endinterface

interface lag_out_if import lag_pkg::*; ();
  logic valid;
  logic ready;
  logic read_value;

  modport source (output valid, read_value, input ready);
  modport sink   (input valid, read_value, output ready);
endinterface

FILE: rtl/lag_datapath.sv
// ----------------------------------------------------------------------------
// lag_datapath
// Grid row memory, size registers, request capture, three-row window and
// rule logic, result and output payload registers.
// ----------------------------------------------------------------------------
module lag_datapath import lag_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [FieldRowW-1:0] row_i,
  input  logic [FieldColW-1:0] col_i,
  input  logic                 write_value_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  input  lag_cmd_t             cmd_i,
  output lag_stat_t            stat_o,
  output logic                 read_value_o
);

  logic [CfgW-1:0]      rows_q, cols_q;
  logic [FieldRowW-1:0] req_row_q;
  logic [FieldColW-1:0] req_col_q;
  logic                 req_wv_q;
  logic                 res_q, out_q;

  logic [WideW-1:0] rows_w, cols_w, nr_w, nc_w;
  logic [CntW-1:0]  nr;
  logic [NcW-1:0]   nc;
  logic             in_area;
  row_word_t        col_mask, sel;

  row_word_t        mem_q [Depth];
  logic [Depth-1:0] vld_q;
  row_word_t        rdata_q;
  logic             rvld_q;
  row_word_t        rword;
  logic             rd_en, wr_en;
  logic [RowW-1:0]  rd_addr, wr_addr;
  row_word_t        wr_data, cell_word, new_row;

  row_word_t        prev_q, cur_q, nxt_q;

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RegReset;
      cols_q <= RegReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS: rows_q <= cfg_wdata_i;
        CFG_COLS: cols_q <= cfg_wdata_i;
        default:  rows_q <= rows_q;
      endcase
    end
  end

  // Clamp sizes into 1..max
  always_comb begin
    rows_w = WideW'(rows_q);
    cols_w = WideW'(cols_q);
    if (rows_w == '0) begin
      nr_w = WideW'(1);
    end else if (rows_w > WideW'(MaxRows)) begin
      nr_w = WideW'(MaxRows);
    end else begin
      nr_w = rows_w;
    end
    if (cols_w == '0) begin
      nc_w = WideW'(1);
    end else if (cols_w > WideW'(MaxCols)) begin
      nc_w = WideW'(MaxCols);
    end else begin
      nc_w = cols_w;
    end
  end

  assign nr = CntW'(nr_w);
  assign nc = NcW'(nc_w);
  assign stat_o.nr = nr;

  always_comb begin
    for (int c = 0; c < MaxCols; c++) begin
      col_mask[c] = (NcW'(c) < nc);
      sel[c]      = (FieldColW'(c) == req_col_q);
    end
  end

  assign in_area = (WideW'(req_row_q) < nr_w) && (WideW'(req_col_q) < nc_w);

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_row_q <= row_i;
      req_col_q <= col_i;
      req_wv_q  <= write_value_i;
    end
  end

  // Row memory; rows never written read as dead
  assign rd_en   = cmd_i.req_rd | cmd_i.adv_rd;
  assign rd_addr = cmd_i.adv_rd ? cmd_i.rd_addr : RowW'(req_row_q);
  assign wr_en   = (cmd_i.cell_wr && in_area) || cmd_i.adv_wr;
  assign wr_addr = cmd_i.adv_wr ? cmd_i.wr_addr : RowW'(req_row_q);
  assign rword   = rvld_q ? rdata_q : '0;

  assign cell_word = req_wv_q ? (rword | sel) : (rword & ~sel);
  assign new_row   = lag_next_row(prev_q, cur_q, nxt_q, col_mask);
  assign wr_data   = cmd_i.adv_wr ? new_row : cell_word;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[rd_addr];
      end
    end
  end

  // Three-row window over the old grid
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_clr) begin
      prev_q <= '0;
      cur_q  <= '0;
      nxt_q  <= '0;
    end else if (cmd_i.shift) begin
      prev_q <= cur_q;
      cur_q  <= nxt_q;
      nxt_q  <= cmd_i.blank ? '0 : rword;
    end
  end

  // Result and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      res_q <= 1'b0;
    end else if (cmd_i.res_cap) begin
      res_q <= in_area && (|(rword & sel));
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign read_value_o = out_q;

endmodule

FILE: rtl/lag_ctrl.sv
// ----------------------------------------------------------------------------
// lag_ctrl
// Sequencer for cell write, cell read and generation sweep, plus the output
// valid flag.
// ----------------------------------------------------------------------------
module lag_ctrl import lag_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [OpW-1:0] op_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  lag_stat_t      stat_i,
  output lag_cmd_t       cmd_o
);

  `include "life_automaton_grid_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_RD,
    ST_WR_UPD,
    ST_RD_RD,
    ST_RD_DATA,
    ST_ADV,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic            accept;
  logic [CntW-1:0] nr_p1, nr_p2;
  lag_cmd_t        cmd;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign nr_p1       = stat_i.nr + CntW'(1);
  assign nr_p2       = stat_i.nr + CntW'(2);
  assign cmd_o       = cmd;

  always_comb begin
    cmd         = '0;
    cmd.cap     = accept;
    cmd.win_clr = accept && (op_i == OP_ADVANCE);
    unique case (state_q)
      ST_WR_RD:   cmd.req_rd  = 1'b1;
      ST_WR_UPD:  cmd.cell_wr = 1'b1;
      ST_RD_RD:   cmd.req_rd  = 1'b1;
      ST_RD_DATA: cmd.res_cap = 1'b1;
      ST_ADV: begin
        // Read row cnt, shift in row cnt-1, write row cnt-3
        cmd.adv_rd  = (cnt_q < stat_i.nr);
        cmd.rd_addr = RowW'(cnt_q);
        cmd.shift   = (cnt_q != '0) && (cnt_q <= nr_p1);
        cmd.blank   = (cnt_q > stat_i.nr);
        cmd.adv_wr  = (cnt_q >= CntW'(3));
        cmd.wr_addr = RowW'(cnt_q - CntW'(3));
      end
      ST_DONE:    cmd.out_load = !out_valid_q || out_ready_i;
      default:    cmd.cap = accept;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            unique case (op_i)
              OP_WRITE:   state_q <= ST_WR_RD;
              OP_READ:    state_q <= ST_RD_RD;
              OP_ADVANCE: begin
                state_q <= ST_ADV;
                cnt_q   <= '0;
              end
              default:    state_q <= ST_DONE;
            endcase
          end
        end
        ST_WR_RD:   state_q <= ST_WR_UPD;
        ST_WR_UPD:  state_q <= ST_DONE;
        ST_RD_RD:   state_q <= ST_RD_DATA;
        ST_RD_DATA: state_q <= ST_DONE;
        ST_ADV: begin
          if (cnt_q == nr_p2) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        ST_DONE: begin
          if (cmd.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `LAG_ASSERT_IMP(a_sweep_no_hazard, cmd.adv_rd && cmd.adv_wr, cmd.wr_addr < cmd.rd_addr, "sweep writes a row not yet read")
  `LAG_ASSERT_IMP(a_sweep_bound, state_q == ST_ADV, cnt_q <= nr_p2, "sweep counter overran")
  `LAG_ASSERT_NXT(a_sweep_end, state_q == ST_ADV && cnt_q == nr_p2, state_q == ST_DONE, "sweep did not finish")
  `LAG_ASSERT_NXT(a_adv_start, accept && op_i == OP_ADVANCE, state_q == ST_ADV && cnt_q == '0, "advance did not start at row zero")

endmodule

FILE: rtl/life_automaton_grid.sv
// ----------------------------------------------------------------------------
// life_automaton_grid: B3/S23 cell grid with write, read and advance beats.
// Sequence: write and read each take a memory read, then an update or capture
//   state, then the result state; an unused code goes straight to the result state.
// Beats are taken one at a time, when idle; the rows sweep through one read port.
// Reset: all cells dead at once through per-row flags, sizes 64 by 64.
// ----------------------------------------------------------------------------
module life_automaton_grid import lag_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  lag_in_if.sink             in_if,
  lag_out_if.source          out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  lag_cmd_t  cmd;
  lag_stat_t stat;

  lag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .op_i        (in_if.operation),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lag_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_i         (in_if.row),
    .col_i         (in_if.col),
    .write_value_i (in_if.write_value),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .read_value_o  (out_if.read_value)
  );

endmodule
